@@ design/color_key_sprite_blit_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Color key sprite blit assertion macros
// Shared concurrent assertion forms used by the blit modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_SPRITE_BLIT_UNIT_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLIT_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CKB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ckb assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ckb assertion failed");

`endif

@@ design/ckb_pkg.sv @@
// ----------------------------------------------------------------------------
// Color key sprite blit package
// Shared types, codes and widths of the sprite blit unit.
// ----------------------------------------------------------------------------
package ckb_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 96;

   // input item kind, carried in req_tuser
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_BYTES   = 2'd2;
   localparam logic [1:0] CSR_KEY_COLOR     = 2'd3;

   typedef enum logic [1:0] {
      ACT_SKIP    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_ERROR   = 2'd2,
      ACT_IGNORED = 2'd3
   } action_type;

   // request payload, last declared field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] pixel_color;
      logic        mirror;
      logic [15:0] sprite_height;
      logic [15:0] sprite_width;
      logic [15:0] corner_y;
      logic [15:0] corner_x;
   } req_data_type;

   // response payload, last declared field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [2:0]  byte_count;
      logic [31:0] write_data;
      logic [25:0] byte_address;
      logic [31:0] source_index;
   } rsp_data_type;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [2:0]  pixel_bytes;
      logic [31:0] key_color;
   } cfg_type;

   // classified pixel handed from front to back
   typedef struct packed {
      action_type  action;
      logic [31:0] source_index;
      logic [15:0] dx;
      logic [15:0] dy;
      logic [31:0] color;
      logic        last;
   } entry_type;

endpackage

@@ design/ckb_queue.sv @@
// ----------------------------------------------------------------------------
// Color key sprite blit queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
`include "color_key_sprite_blit_unit_assert.svh"

module ckb_queue
   import ckb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CKB_ASSERT_SAME(a_no_overflow, clock, reset, push, !full)
   `CKB_ASSERT_SAME(a_no_underflow, clock, reset, pop, !empty)
   `CKB_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `CKB_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

@@ design/ckb_front.sv @@
// ----------------------------------------------------------------------------
// Color key sprite blit front
// Accepts start and pixel items, walks the sprite and classifies each pixel.
// ----------------------------------------------------------------------------
module ckb_front
   import ckb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output entry_type             q_entry
);

   req_data_type req;

   logic [15:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [15:0] bw_ff, bw_in, bh_ff, bh_in;
   logic [15:0] row_ff, row_in, col_ff, col_in;
   logic [31:0] base_ff, base_in;
   logic        mirror_ff, mirror_in, failed_ff, failed_in;

   logic        accept, active, col_end, oob;
   logic [15:0] src_col, dx, dy;
   action_type  action;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign active     = (bw_ff != '0) && (row_ff < bh_ff);

   always_comb begin
      src_col = mirror_ff ? (bw_ff - 16'd1 - col_ff) : col_ff;
      dx      = ox_ff + col_ff;
      dy      = oy_ff + row_ff;
      col_end = col_ff == bw_ff - 16'd1;
      oob     = (dx >= {3'b000, cfg.screen_width}) || (dy >= {3'b000, cfg.screen_height});
      if (failed_ff) begin
         action = ACT_IGNORED;
      end else if (req.pixel_color == cfg.key_color) begin
         action = ACT_SKIP;
      end else if (oob) begin
         action = ACT_ERROR;
      end else begin
         action = ACT_WRITE;
      end
      q_push               = accept && (req_tuser == KIND_PIXEL) && active;
      q_entry.action       = action;
      q_entry.source_index = base_ff + {16'h0000, src_col};
      q_entry.dx           = dx;
      q_entry.dy           = dy;
      q_entry.color        = req.pixel_color;
      q_entry.last         = col_end && (row_ff == bh_ff - 16'd1);
   end

   always_comb begin
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      bw_in     = bw_ff;
      bh_in     = bh_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      base_in   = base_ff;
      mirror_in = mirror_ff;
      failed_in = failed_ff;
      if (accept && req_tuser == KIND_START) begin
         ox_in     = req.corner_x;
         oy_in     = req.corner_y;
         bw_in     = req.sprite_width;
         bh_in     = req.sprite_height;
         mirror_in = req.mirror;
         row_in    = '0;
         col_in    = '0;
         base_in   = '0;
         failed_in = 1'b0;
      end else if (q_push) begin
         failed_in = failed_ff || (action == ACT_ERROR);
         // advance to the next source position, row base follows the row
         if (col_end) begin
            col_in  = '0;
            row_in  = row_ff + 16'd1;
            base_in = base_ff + {16'h0000, bw_ff};
         end else begin
            col_in = col_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff     <= '0;
         oy_ff     <= '0;
         bw_ff     <= '0;
         bh_ff     <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         base_ff   <= '0;
         mirror_ff <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         base_ff   <= base_in;
         mirror_ff <= mirror_in;
         failed_ff <= failed_in;
      end
   end

endmodule

@@ design/ckb_back.sv @@
// ----------------------------------------------------------------------------
// Color key sprite blit back
// Turns classified pixels into framebuffer addresses and masked write data.
// ----------------------------------------------------------------------------
module ckb_back
   import ckb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  entry_type             q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   entry_type    s1_entry_ff;
   logic [29:0]  s1_lin_ff, s1_lin_in;
   logic         s1_valid_ff, s1_valid_in;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff, out_data_in;
   action_type   out_action_ff;
   logic         out_last_ff;

   logic         out_advance, s1_advance;
   logic [28:0]  prod;
   logic [2:0]   nb;
   logic [31:0]  scaled;
   logic [31:0]  mask;

   assign out_advance = !out_valid_ff || rsp_tready;
   assign s1_advance  = !s1_valid_ff || out_advance;
   assign q_pop       = s1_advance && !q_empty;

   // row-major pixel offset: dy * screen_width + dx
   assign prod      = 29'(q_head.dy) * 29'(cfg.screen_width);
   assign s1_lin_in = 30'(prod) + 30'(q_head.dx);

   always_comb begin
      if (cfg.pixel_bytes == 3'd0) begin
         nb = 3'd1;
      end else if (cfg.pixel_bytes > 3'd4) begin
         nb = 3'd4;
      end else begin
         nb = cfg.pixel_bytes;
      end
      case (nb)
         3'd1: begin
            scaled = 32'(s1_lin_ff);
            mask   = 32'h0000_00FF;
         end
         3'd2: begin
            scaled = {1'b0, s1_lin_ff, 1'b0};
            mask   = 32'h0000_FFFF;
         end
         3'd3: begin
            scaled = 32'(s1_lin_ff) + {1'b0, s1_lin_ff, 1'b0};
            mask   = 32'h00FF_FFFF;
         end
         default: begin
            scaled = {s1_lin_ff, 2'b00};
            mask   = 32'hFFFF_FFFF;
         end
      endcase
      out_data_in              = '0;
      out_data_in.source_index = s1_entry_ff.source_index;
      out_data_in.byte_count   = nb;
      if (s1_entry_ff.action == ACT_WRITE) begin
         out_data_in.byte_address = scaled[25:0];
         out_data_in.write_data   = s1_entry_ff.color & mask;
      end
      s1_valid_in  = s1_advance ? !q_empty : s1_valid_ff;
      out_valid_in = out_advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff <= q_head;
         s1_lin_ff   <= s1_lin_in;
      end
      if (out_advance && s1_valid_ff) begin
         out_data_ff   <= out_data_in;
         out_action_ff <= s1_entry_ff.action;
         out_last_ff   <= s1_entry_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ design/color_key_sprite_blit_unit.sv @@
// A pixel item goes from the queue via the stage-one register into the output register.
// Throughput: one item per cycle while rsp_tready is high; the address multiply and byte scaling sit in the back.
// Start items, pixels beyond the sprite and pixels of an empty sprite give no result.
// Reset (synchronous, active high) restores the screen registers to 1024 x 768, 4 bytes
// per pixel, key 0, clears the blit state and empties the queue and output stage.
// ----------------------------------------------------------------------------
// Color key sprite blit unit
// Top level: configuration registers, front classifier, queue and address back end.
// ----------------------------------------------------------------------------
module color_key_sprite_blit_unit
   import ckb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // corner_x, corner_y, sprite_width, sprite_height, mirror, pixel_color, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // source_index, byte_address, write_data, byte_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // action
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_entry, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[12:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[12:0];
            CSR_PIXEL_BYTES:   cfg_in.pixel_bytes   = csr_data[2:0];
            CSR_KEY_COLOR:     cfg_in.key_color     = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= 13'd1024;
         cfg_ff.screen_height <= 13'd768;
         cfg_ff.pixel_bytes   <= 3'd4;
         cfg_ff.key_color     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ckb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   ckb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   ckb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
